// File: sv/mcpva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpva_pkg
// Shared types, constants and helpers of the MIDI parser and voice allocator.
// ----------------------------------------------------------------------------
package mcpva_pkg;

	// voice slots and derived widths
	localparam int VOICE_SLOTS = 8;
	localparam int SLOT_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
	localparam int CNT_W = $clog2(VOICE_SLOTS + 1);
	localparam int CTRL_DEPTH = 128;
	localparam int QDEPTH = 2;

	localparam logic [6:0] AGE_MAX = 7'd127;
	localparam logic [13:0] BEND_CENTER = 14'd8192;
	localparam logic [7:0] BYTE_RESET = 8'hFF;

	// input opcodes
	localparam logic [2:0] OP_MIDI = 3'd0;
	localparam logic [2:0] OP_CLR_TRIG = 3'd1;
	localparam logic [2:0] OP_RD_VOICE = 3'd2;
	localparam logic [2:0] OP_RD_CTRL = 3'd3;
	localparam logic [2:0] OP_CLR_RESET = 3'd4;

	// result events
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_NOTE_ON = 3'd1;
	localparam logic [2:0] EV_NOTE_OFF = 3'd2;
	localparam logic [2:0] EV_CONTROL = 3'd3;
	localparam logic [2:0] EV_PROGRAM = 3'd4;
	localparam logic [2:0] EV_BEND = 3'd5;
	localparam logic [2:0] EV_READ = 3'd6;

	// midi command codes (status bits 6:4)
	localparam logic [2:0] MC_NOTE_OFF = 3'd0;
	localparam logic [2:0] MC_NOTE_ON = 3'd1;
	localparam logic [2:0] MC_CONTROL = 3'd3;
	localparam logic [2:0] MC_PROGRAM = 3'd4;
	localparam logic [2:0] MC_BEND = 3'd6;

	// configuration register indexes
	localparam logic REG_LISTEN = 1'b0;
	localparam logic REG_VOICES = 1'b1;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic [6:0] index;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [2:0]  slot;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic        gate_on;
		logic        trigger;
		logic [13:0] bend_value;
		logic [6:0]  ctrl_number;
		logic [6:0]  ctrl_value;
		logic [6:0]  program_number;
		logic        reset_seen;
	} result_t;

	// work kinds handed from front to back
	typedef enum logic [3:0] {
		K_NONE, K_NOTE_ON, K_NOTE_OFF, K_CTRL, K_PROG, K_BEND,
		K_CLR_TRIG, K_RD_VOICE, K_RD_CTRL, K_CLR_RESET
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] b0;
		logic [6:0] b1;
		logic [6:0] idx;
		logic       set_reset;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_COMMIT, ST_CTRL_RD, ST_EMIT
	} back_state_t;

	// data bytes each midi command needs
	function automatic logic [1:0] length_of(input logic [2:0] code);
		unique case (code)
			MC_NOTE_OFF, MC_NOTE_ON, MC_CONTROL, MC_BEND: length_of = 2'd2;
			MC_PROGRAM: length_of = 2'd1;
			default: length_of = 2'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: sv/mcpva_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpva_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcpva_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/mcpva_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpva_front
// Byte parser: status, running status, channel filter, data buffer, and a
// two-entry work queue toward the back end.
// ----------------------------------------------------------------------------
module mcpva_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire mcpva_pkg::item_t  item,
	input  wire logic [3:0]        listen_channel,
	output logic                   cmd_valid,
	output mcpva_pkg::cmd_t        cmd,
	input  wire logic              cmd_take
);

	logic [2:0] code_q;
	logic [1:0] len_q;
	logic [1:0] br_q;
	logic [3:0] chan_q;
	logic [6:0] buf_q [2];

	mcpva_pkg::cmd_t q_q [mcpva_pkg::QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	logic            accept;
	logic            is_midi, is_status, ch_ok, done;
	logic [1:0]      br_inc;
	logic [6:0]      low7;
	mcpva_pkg::cmd_t new_cmd;

	assign full = (cnt_q == 2'(mcpva_pkg::QDEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];
	assign accept = push && !full;

	// classify the incoming item
	always_comb begin
		is_midi = (item.opcode == mcpva_pkg::OP_MIDI);
		is_status = item.data_byte[7];
		low7 = item.data_byte[6:0];
		ch_ok = (chan_q == listen_channel);
		br_inc = br_q + 2'd1;
		done = (br_inc >= len_q);
		new_cmd.kind = mcpva_pkg::K_NONE;
		new_cmd.b0 = br_q[0] ? buf_q[0] : low7;
		new_cmd.b1 = br_q[0] ? low7 : buf_q[1];
		new_cmd.idx = item.index;
		new_cmd.set_reset = is_midi && (item.data_byte == mcpva_pkg::BYTE_RESET);
		unique case (item.opcode)
			mcpva_pkg::OP_MIDI: begin
				if (!is_status && ch_ok && done) begin
					unique case (code_q)
						mcpva_pkg::MC_NOTE_ON: new_cmd.kind = mcpva_pkg::K_NOTE_ON;
						mcpva_pkg::MC_NOTE_OFF: new_cmd.kind = mcpva_pkg::K_NOTE_OFF;
						mcpva_pkg::MC_CONTROL: new_cmd.kind = mcpva_pkg::K_CTRL;
						mcpva_pkg::MC_PROGRAM: new_cmd.kind = mcpva_pkg::K_PROG;
						mcpva_pkg::MC_BEND: new_cmd.kind = mcpva_pkg::K_BEND;
						default: new_cmd.kind = mcpva_pkg::K_NONE;
					endcase
				end
			end
			mcpva_pkg::OP_CLR_TRIG: new_cmd.kind = mcpva_pkg::K_CLR_TRIG;
			mcpva_pkg::OP_RD_VOICE: new_cmd.kind = mcpva_pkg::K_RD_VOICE;
			mcpva_pkg::OP_RD_CTRL: new_cmd.kind = mcpva_pkg::K_RD_CTRL;
			mcpva_pkg::OP_CLR_RESET: new_cmd.kind = mcpva_pkg::K_CLR_RESET;
			default: new_cmd.kind = mcpva_pkg::K_NONE;
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= mcpva_pkg::MC_NOTE_OFF;
			len_q <= 2'd0;
			br_q <= 2'd0;
			chan_q <= 4'd0;
		end else if (accept && is_midi) begin
			if (is_status) begin
				code_q <= item.data_byte[6:4];
				chan_q <= item.data_byte[3:0];
				len_q <= mcpva_pkg::length_of(item.data_byte[6:4]);
				br_q <= 2'd0;
			end else if (ch_ok) begin
				br_q <= done ? 2'd0 : br_inc;
			end
		end
	end

	// data buffer, payload only
	always_ff @(posedge clk) begin
		if (accept && is_midi && !is_status && ch_ok) begin
			buf_q[br_q[0]] <= low7;
		end
	end

	// work queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) wp_q <= ~wp_q;
			if (cmd_take && cmd_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(accept) - 2'(cmd_take && cmd_valid);
		end
	end

	// work queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_q[wp_q] <= new_cmd;
		end
	end

endmodule
`default_nettype wire

// File: sv/mcpva_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpva_back
// Executes parsed work: voice scan and allocation, note release, controller
// store, bend and reset flag; queues results two deep.
// ----------------------------------------------------------------------------
module mcpva_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  wire mcpva_pkg::cmd_t     cmd,
	output logic                     cmd_take,
	input  wire logic [3:0]          voices_in_use,
	output logic                     empty,
	input  wire logic                pop,
	output mcpva_pkg::result_t       result
);

	localparam int SW = mcpva_pkg::SLOT_W;
	localparam int CW = mcpva_pkg::CNT_W;
	localparam int NV = mcpva_pkg::VOICE_SLOTS;

	mcpva_pkg::back_state_t state_q, state_d;

	logic [6:0] note_q [NV];
	logic [6:0] vel_q  [NV];
	logic [6:0] age_q  [NV];
	logic [NV-1:0] gate_q, trig_q;
	logic [13:0] bend_q;
	logic        rflag_q;
	logic [mcpva_pkg::CTRL_DEPTH-1:0] cvld_q;
	logic        cvld_rd_q;
	logic [6:0]  ram_rdata;

	mcpva_pkg::cmd_t    cur_q;
	mcpva_pkg::result_t res_q;
	logic [SW-1:0] scan_q, free_q, gated_q;
	logic          have_free_q, have_gated_q;

	mcpva_pkg::result_t oq_q [mcpva_pkg::QDEPTH];
	logic       owp_q, orp_q;
	logic [1:0] ocnt_q;

	logic [CW-1:0] n_act;
	logic          oq_full, do_emit, do_pop, ram_we;
	logic [SW-1:0] pick;
	logic [SW-1:0] rd_slot;
	logic          rd_ok;
	mcpva_pkg::result_t emit_res;
	mcpva_pkg::result_t take_res;

	assign empty = (ocnt_q == 2'd0);
	assign result = oq_q[orp_q];
	assign oq_full = (ocnt_q == 2'(mcpva_pkg::QDEPTH));
	assign do_pop = pop && !empty;

	// number of slots in play
	always_comb begin
		if (voices_in_use == 4'd0) begin
			n_act = CW'(1);
		end else if (32'(voices_in_use) > NV) begin
			n_act = CW'(NV);
		end else begin
			n_act = CW'(voices_in_use);
		end
	end

	assign pick = have_free_q ? free_q : gated_q;
	assign rd_slot = cmd.idx[SW-1:0];
	assign rd_ok = (32'(cmd.idx) < NV);
	assign ram_we = (state_q == mcpva_pkg::ST_IDLE) && cmd_valid
		&& (cmd.kind == mcpva_pkg::K_CTRL);

	// result with live bend and reset flag
	always_comb begin
		emit_res = res_q;
		emit_res.bend_value = bend_q;
		emit_res.reset_seen = rflag_q;
	end

	// result fields known when work is taken
	always_comb begin
		take_res = '0;
		unique case (cmd.kind)
			mcpva_pkg::K_NOTE_OFF: begin
				take_res.event_res = mcpva_pkg::EV_NOTE_OFF;
				take_res.note = cmd.b0;
			end
			mcpva_pkg::K_CTRL: begin
				take_res.event_res = mcpva_pkg::EV_CONTROL;
				take_res.ctrl_number = cmd.b0;
				take_res.ctrl_value = cmd.b1;
			end
			mcpva_pkg::K_PROG: begin
				take_res.event_res = mcpva_pkg::EV_PROGRAM;
				take_res.program_number = cmd.b0;
			end
			mcpva_pkg::K_BEND: take_res.event_res = mcpva_pkg::EV_BEND;
			mcpva_pkg::K_RD_VOICE: begin
				take_res.event_res = mcpva_pkg::EV_READ;
				take_res.slot = cmd.idx[2:0];
				if (rd_ok) begin
					take_res.note = note_q[rd_slot];
					take_res.velocity = vel_q[rd_slot];
					take_res.gate_on = gate_q[rd_slot];
					take_res.trigger = trig_q[rd_slot];
				end
			end
			mcpva_pkg::K_RD_CTRL: begin
				take_res.event_res = mcpva_pkg::EV_READ;
				take_res.ctrl_number = cmd.idx;
			end
			default: ;
		endcase
	end

	// controller store
	mcpva_ram #(.WIDTH(7), .DEPTH(mcpva_pkg::CTRL_DEPTH)) u_ctrl_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd.b0),
		.wdata(cmd.b1),
		.raddr(cmd.idx),
		.rdata(ram_rdata)
	);

	// next state and handshake
	always_comb begin
		state_d = state_q;
		cmd_take = 1'b0;
		do_emit = 1'b0;
		unique case (state_q)
			mcpva_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					unique case (cmd.kind)
						mcpva_pkg::K_NOTE_ON: state_d = mcpva_pkg::ST_SCAN;
						mcpva_pkg::K_RD_CTRL: state_d = mcpva_pkg::ST_CTRL_RD;
						default: state_d = mcpva_pkg::ST_EMIT;
					endcase
				end
			end
			mcpva_pkg::ST_SCAN: begin
				if (CW'(scan_q) + CW'(1) == n_act) state_d = mcpva_pkg::ST_COMMIT;
			end
			mcpva_pkg::ST_COMMIT: state_d = mcpva_pkg::ST_EMIT;
			mcpva_pkg::ST_CTRL_RD: state_d = mcpva_pkg::ST_EMIT;
			mcpva_pkg::ST_EMIT: begin
				if (!oq_full) begin
					do_emit = 1'b1;
					state_d = mcpva_pkg::ST_IDLE;
				end
			end
			default: state_d = mcpva_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mcpva_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// voice, bend, flag and controller valid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) begin
				note_q[i] <= 7'd0;
				vel_q[i] <= 7'd0;
				age_q[i] <= 7'd0;
			end
			gate_q <= '0;
			trig_q <= '0;
			bend_q <= mcpva_pkg::BEND_CENTER;
			rflag_q <= 1'b0;
			cvld_q <= '0;
			cvld_rd_q <= 1'b0;
			scan_q <= '0;
			free_q <= '0;
			gated_q <= '0;
			have_free_q <= 1'b0;
			have_gated_q <= 1'b0;
		end else begin
			cvld_rd_q <= cvld_q[cmd.idx];
			if (cmd_take) begin
				scan_q <= '0;
				have_free_q <= 1'b0;
				have_gated_q <= 1'b0;
				if (cmd.set_reset) rflag_q <= 1'b1;
				unique case (cmd.kind)
					mcpva_pkg::K_NOTE_OFF: begin
						for (int i = 0; i < NV; i++) begin
							if (note_q[i] == cmd.b0) begin
								gate_q[i] <= 1'b0;
								trig_q[i] <= 1'b0;
							end
						end
					end
					mcpva_pkg::K_CTRL: cvld_q[cmd.b0] <= 1'b1;
					mcpva_pkg::K_BEND: bend_q <= {cmd.b1, cmd.b0};
					mcpva_pkg::K_CLR_TRIG: trig_q <= '0;
					mcpva_pkg::K_CLR_RESET: rflag_q <= 1'b0;
					default: ;
				endcase
			end
			// one slot examined per cycle, oldest wins, ties to lowest
			if (state_q == mcpva_pkg::ST_SCAN) begin
				scan_q <= scan_q + SW'(1);
				if (gate_q[scan_q]) begin
					if (!have_gated_q || age_q[scan_q] > age_q[gated_q]) begin
						gated_q <= scan_q;
						have_gated_q <= 1'b1;
					end
				end else begin
					if (!have_free_q || age_q[scan_q] > age_q[free_q]) begin
						free_q <= scan_q;
						have_free_q <= 1'b1;
					end
				end
			end
			// age slots in play and load the chosen one
			if (state_q == mcpva_pkg::ST_COMMIT) begin
				for (int i = 0; i < NV; i++) begin
					if (SW'(i) == pick) begin
						age_q[i] <= 7'd0;
					end else if (CW'(i) < n_act && age_q[i] < mcpva_pkg::AGE_MAX) begin
						age_q[i] <= age_q[i] + 7'd1;
					end
				end
				gate_q[pick] <= 1'b1;
				trig_q[pick] <= 1'b1;
				note_q[pick] <= cur_q.b0;
				vel_q[pick] <= cur_q.b1;
			end
		end
	end

	// result assembly, payload only
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q <= cmd;
			res_q <= take_res;
		end
		if (state_q == mcpva_pkg::ST_CTRL_RD) begin
			res_q.ctrl_value <= cvld_rd_q ? ram_rdata : 7'd0;
		end
		if (state_q == mcpva_pkg::ST_COMMIT) begin
			res_q.event_res <= mcpva_pkg::EV_NOTE_ON;
			res_q.slot <= 3'(pick);
			res_q.note <= cur_q.b0;
			res_q.velocity <= cur_q.b1;
			res_q.gate_on <= 1'b1;
			res_q.trigger <= 1'b1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (do_emit) owp_q <= ~owp_q;
			if (do_pop) orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + 2'(do_emit) - 2'(do_pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (do_emit) begin
			oq_q[owp_q] <= emit_res;
		end
	end

endmodule
`default_nettype wire

// File: sv/midi_channel_parser_voice_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_channel_parser_voice_allocator_top
// MIDI byte parser with oldest-voice allocation and a controller store.
//
//   channel   ports                             accepted when
//   input     push, full, item                  push && !full
//   result    empty, pop, result                pop && !empty
//   config    cfg_we, cfg_index, cfg_data       cfg_we
//
// Front accepts one item per cycle while its two-entry work queue has room.
// Back takes one item at a time and then emits its result; a controller
// read adds a RAM read state, and a note on adds a scan of the n voice
// slots in play (one slot per scan cycle) and a commit state. Results
// wait in a two-entry queue; a full queue stalls the back end, then the
// front. No clearing pass after reset: controller entries carry valid bits.
// ----------------------------------------------------------------------------
module midi_channel_parser_voice_allocator_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire mcpva_pkg::item_t    item,
	output logic                     empty,
	input  wire logic                pop,
	output mcpva_pkg::result_t       result,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [3:0]          cfg_data
);

	logic [3:0] listen_q, voices_q;
	logic            cmd_valid, cmd_take;
	mcpva_pkg::cmd_t cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_q <= 4'd0;
			voices_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcpva_pkg::REG_LISTEN: listen_q <= cfg_data;
				mcpva_pkg::REG_VOICES: voices_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mcpva_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.item          (item),
		.listen_channel(listen_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_take      (cmd_take)
	);

	mcpva_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.voices_in_use(voices_q),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule
`default_nettype wire

// File: sv/mcpva_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpva_checker
// Port-level checks of the parser and voice allocator, bound to the top.
// ----------------------------------------------------------------------------
module mcpva_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire mcpva_pkg::result_t result
);

	// nothing waits right after reset
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	// head result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// note on always reports a set gate and trigger
	a_note_on: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.event_res == mcpva_pkg::EV_NOTE_ON |-> result.gate_on && result.trigger)
		else $error("note on without marks");

	// event codes stay in range
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.event_res <= mcpva_pkg::EV_READ)
		else $error("bad event code");

endmodule

bind midi_channel_parser_voice_allocator_top mcpva_checker u_mcpva_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
`default_nettype wire
